// ----- hdl/u16u8_pkg.sv -----
package u16u8_pkg;

    localparam logic [15:0] UNIT_HIGH_SURR = 16'hD800;
    localparam logic [15:0] UNIT_LOW_SURR  = 16'hDC00;
    localparam logic [15:0] UNIT_SURR_END  = 16'hE000;
    localparam logic [15:0] UNIT_ASCII_END = 16'h0080;
    localparam logic [15:0] UNIT_TWO_END   = 16'h0800;
    localparam logic [20:0] CP_SUPP_BASE   = 21'h10000;
    localparam logic [7:0]  CONT_MARK      = 8'h80;
    localparam logic [5:0]  CONT_MASK      = 6'h3F;

    localparam int          CP_W           = 21;

    // Lead byte marks, indexed by the number of continuation bytes minus one.
    localparam logic [7:0] LEAD_MARKS [3] = '{8'hC0, 8'hE0, 8'hF0};

    // One job for the back end: last_idx is the byte count minus one.
    typedef struct packed {
        logic [1:0]      last_idx;
        logic            err;
        logic            str_end;
        logic [CP_W-1:0] cp;
    } t_job;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       conversion_error;
        logic       string_end;
    } t_result;

endpackage

// ----- hdl/utf16_to_utf8_encoder_unit.sv -----
// UTF-16 to UTF-8 stream encoder.
// Input channel: drive i_code_unit and raise i_push; a beat is taken at a rising
// edge with i_push high and o_full low. Strings end with a zero code unit.
// Result channel: while o_empty is low the oldest UTF-8 byte sits on o_out_byte
// with its flags; raise i_pop to take that beat.
// Each unit yields one to four byte beats (a high surrogate yields none until
// its low partner arrives; malformed surrogates yield one error beat and the
// rest of the string is dropped through its terminating zero).
// A unit's job passes through the queue, and its bytes through the output register.
// Throughput: one byte beat per cycle while i_pop takes each beat, so ASCII runs
// at one unit per cycle; a multi-byte unit occupies the byte emitter for each of its bytes.
// The front end classifies units and tracks surrogate/drop state; a queue of
// QUEUE_DEPTH jobs lets it keep taking units while the back end works off
// multi-byte jobs. o_full rises only when that queue fills.
// When the receiver stalls, the output register holds its byte, the queue
// fills and then o_full stops the sender; no beat is lost.
// Reset (synchronous, active low) empties the queue and the output register
// and clears held surrogate and drop state.
module utf16_to_utf8_encoder_unit #(
    parameter int QUEUE_DEPTH = 4   // power of two, at least 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_code_unit,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_conversion_error,
    output logic        o_string_end
);

    logic               accept;
    logic               job_valid;
    u16u8_pkg::t_job    job_in, job_head;
    logic               q_full, q_empty, job_done;
    logic               out_valid;
    u16u8_pkg::t_result out;

    // Take a beat whenever the queue has room; jobs-less units still advance state.
    assign accept = i_push && !q_full;
    assign o_full = q_full;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_unit (i_code_unit),
        .o_job_valid (job_valid),
        .o_job       (job_in)
    );

    u16u8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept && job_valid),
        .i_wr_job (job_in),
        .o_full   (q_full),
        .i_rd     (job_done),
        .o_empty  (q_empty),
        .o_rd_job (job_head)
    );

    // One byte per unstalled cycle from the head job; drop the job after its last byte.
    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (job_head),
        .o_job_done  (job_done),
        .o_out_valid (out_valid),
        .o_out       (out),
        .i_out_take  (i_pop)
    );

    assign o_empty            = !out_valid;
    assign o_out_byte         = out.out_byte;
    assign o_last_of_run      = out.last_of_run;
    assign o_conversion_error = out.conversion_error;
    assign o_string_end       = out.string_end;

endmodule

// ----- hdl/u16u8_front.sv -----
module u16u8_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [15:0]      i_code_unit,
    output logic             o_job_valid,
    output u16u8_pkg::t_job  o_job
);

    logic [9:0] r_held_bits, n_held_bits;
    logic       r_held,      n_held;
    logic       r_dropping,  n_dropping;

    logic is_zero, is_high, is_low;

    assign is_zero = (i_code_unit == 16'd0);
    assign is_high = (i_code_unit >= u16u8_pkg::UNIT_HIGH_SURR)
                   && (i_code_unit < u16u8_pkg::UNIT_LOW_SURR);
    assign is_low  = (i_code_unit >= u16u8_pkg::UNIT_LOW_SURR)
                   && (i_code_unit < u16u8_pkg::UNIT_SURR_END);

    always_comb begin
        n_held_bits = r_held_bits;
        n_held      = r_held;
        n_dropping  = r_dropping;
        o_job_valid = 1'b0;
        o_job       = '0;
        if (r_dropping) begin
            if (is_zero) begin
                n_dropping = 1'b0;
            end
        end else if (r_held) begin
            n_held      = 1'b0;
            n_held_bits = '0;
            o_job_valid = 1'b1;
            if (!is_low) begin
                o_job.err  = 1'b1;
                n_dropping = !is_zero;
            end else begin
                o_job.last_idx = 2'd3;
                o_job.cp = {1'b0, r_held_bits, i_code_unit[9:0]} + u16u8_pkg::CP_SUPP_BASE;
            end
        end else if (is_zero) begin
            o_job_valid   = 1'b1;
            o_job.str_end = 1'b1;
        end else if (i_code_unit < u16u8_pkg::UNIT_ASCII_END) begin
            o_job_valid = 1'b1;
            o_job.cp    = {5'd0, i_code_unit};
        end else if (is_high) begin
            n_held      = 1'b1;
            n_held_bits = i_code_unit[9:0];
        end else if (is_low) begin
            o_job_valid = 1'b1;
            o_job.err   = 1'b1;
            n_dropping  = 1'b1;
        end else begin
            o_job_valid    = 1'b1;
            o_job.cp       = {5'd0, i_code_unit};
            o_job.last_idx = (i_code_unit < u16u8_pkg::UNIT_TWO_END) ? 2'd1 : 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bits <= '0;
            r_held      <= 1'b0;
            r_dropping  <= 1'b0;
        end else if (i_accept) begin
            r_held_bits <= n_held_bits;
            r_held      <= n_held;
            r_dropping  <= n_dropping;
        end
    end

endmodule

// ----- hdl/u16u8_fifo.sv -----
module u16u8_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  u16u8_pkg::t_job  i_wr_job,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output u16u8_pkg::t_job  o_rd_job
);

    localparam int PTR_W = $clog2(DEPTH);

    u16u8_pkg::t_job r_mem [DEPTH];
    logic [PTR_W:0]  r_wr_ptr, r_rd_ptr;

    assign o_empty  = (r_wr_ptr == r_rd_ptr);
    assign o_full   = (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W])
                   && (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]);
    assign o_rd_job = r_mem[r_rd_ptr[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

// ----- hdl/u16u8_back.sv -----
module u16u8_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  u16u8_pkg::t_job    i_job,
    output logic               o_job_done,
    output logic               o_out_valid,
    output u16u8_pkg::t_result o_out,
    input  logic               i_out_take
);

    logic [1:0]          r_idx;
    logic                r_out_valid;
    u16u8_pkg::t_result  r_out, n_out;
    logic                load;
    logic [1:0]          grp_sel;

    function automatic logic [5:0] cp_group(input logic [20:0] cp, input logic [1:0] sel);
        logic [5:0] g;
        case (sel)
            2'd0:    g = cp[5:0];
            2'd1:    g = cp[11:6];
            2'd2:    g = cp[17:12];
            default: g = {3'd0, cp[20:18]};
        endcase
        return g;
    endfunction

    assign load       = !r_out_valid || i_out_take;
    assign o_job_done = load && i_job_valid && (r_idx == i_job.last_idx);
    assign grp_sel    = (r_idx == 2'd0) ? i_job.last_idx : (i_job.last_idx - r_idx);

    always_comb begin
        n_out                  = '0;
        n_out.last_of_run      = (r_idx == i_job.last_idx);
        n_out.conversion_error = i_job.err;
        n_out.string_end       = i_job.str_end;
        if (i_job.last_idx == 2'd0) begin
            n_out.out_byte = i_job.cp[7:0];
        end else if (r_idx == 2'd0) begin
            n_out.out_byte = u16u8_pkg::LEAD_MARKS[i_job.last_idx - 2'd1]
                           | {2'd0, cp_group(i_job.cp, grp_sel)};
        end else begin
            n_out.out_byte = u16u8_pkg::CONT_MARK
                           | {2'd0, cp_group(i_job.cp, grp_sel) & u16u8_pkg::CONT_MASK};
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_job_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_job_valid;
            if (i_job_valid) begin
                r_idx <= o_job_done ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- hdl/u16u8_checker.sv -----
module u16u8_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_full,
    input logic        o_empty,
    input logic        i_pop,
    input logic [7:0]  o_out_byte,
    input logic        o_last_of_run,
    input logic        o_conversion_error,
    input logic        o_string_end
);

    // Reset leaves both sides idle.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queue not idle after reset");

    // An error beat is a single zero byte that closes its run.
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_conversion_error) |->
            (o_out_byte == 8'd0 && o_last_of_run && !o_string_end))
        else $error("malformed error beat");

    // A string end beat is a lone zero byte.
    a_end_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_string_end) |->
            (o_out_byte == 8'd0 && o_last_of_run && !o_conversion_error))
        else $error("malformed string end beat");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=>
            (!o_empty && $stable(o_out_byte) && $stable(o_last_of_run)
             && $stable(o_conversion_error) && $stable(o_string_end)))
        else $error("result beat changed while stalled");

endmodule

bind utf16_to_utf8_encoder_unit u16u8_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_full             (o_full),
    .o_empty            (o_empty),
    .i_pop              (i_pop),
    .o_out_byte         (o_out_byte),
    .o_last_of_run      (o_last_of_run),
    .o_conversion_error (o_conversion_error),
    .o_string_end       (o_string_end)
);
